// ===== src/eqbd_pkg.sv =====
`default_nettype none

package eqbd_pkg;

	// Filter lengths and the ring depths that follow from them.
	localparam int HP_LEN     = 30;
	localparam int LP_LEN     = 30;
	localparam int HP_DEPTH   = HP_LEN + 1;
	localparam int LP_DEPTH   = LP_LEN + 1;
	localparam int HP_AW      = $clog2(HP_DEPTH);
	localparam int LP_AW      = $clog2(LP_DEPTH);
	// Distance of the center tap, expressed as a forward offset in the ring.
	localparam int HP_CTR_OFS = HP_DEPTH - (HP_LEN + 1) / 2;

	// Datapath widths.
	localparam int X_W    = 16;
	localparam int SUM_W  = 22;
	localparam int HPV_W  = 22;
	localparam int E_W    = 48;
	localparam int WMX_W  = 49;
	localparam int LEN_W  = 10;
	localparam int Q16_W  = 16;
	localparam int CNT_W  = 32;
	localparam int SEEN_W = 11;
	localparam int MA_W   = 32;
	localparam int MB_W   = 24;
	localparam int PROD_W = MA_W + MB_W;
	localparam int ACC_W  = 81;

	localparam logic [SEEN_W-1:0] SEEN_CAP = SEEN_W'(1024);
	localparam logic [WMX_W-1:0]  WMAX_MIN = {1'b1, {(WMX_W-1){1'b0}}};

	// Configuration register reset values.
	localparam logic [Q16_W-1:0] ALPHA_RST = 16'd3604;
	localparam logic [Q16_W-1:0] GAMMA_RST = 16'd11469;
	localparam logic [LEN_W-1:0] WLEN_RST  = 10'd250;
	localparam logic [LEN_W-1:0] HLEN_RST  = 10'd100;

	// Configuration register indexes.
	typedef enum logic [1:0] {
		REG_ALPHA = 2'd0,
		REG_GAMMA = 2'd1,
		REG_WLEN  = 2'd2,
		REG_HLEN  = 2'd3
	} reg_idx_t;

	// Sequencer states.
	typedef enum logic [12:0] {
		ST_IDLE = 13'b0000000000001,
		ST_HP   = 13'b0000000000010,
		ST_SQ   = 13'b0000000000100,
		ST_ACC  = 13'b0000000001000,
		ST_DEC  = 13'b0000000010000,
		ST_AG   = 13'b0000000100000,
		ST_QL   = 13'b0000001000000,
		ST_QH   = 13'b0000010000000,
		ST_WL   = 13'b0000100000000,
		ST_WH   = 13'b0001000000000,
		ST_WFIN = 13'b0010000000000,
		ST_SAT  = 13'b0100000000000,
		ST_DONE = 13'b1000000000000
	} state_t;

endpackage

`default_nettype wire

// ===== src/ecg_qrs_beat_detector.sv =====
// Sequence: an accepted sample passes ST_HP, ST_SQ, ST_ACC and ST_DEC to ST_DONE, with ST_AG
// through ST_SAT between when it closes an adaptation window (threshold update on the shared multiplier).
// A new sample is accepted only in ST_IDLE, after ST_DONE has loaded the result past out_stall;
// the sequencer around one 32x24 multiplier and the registered ring memory reads shape this sequence.
// Reset: all filter sums, threshold, counters and hold-off clear, registers take defaults;
// ring contents are not cleared, the sample fill count masks entries not yet written.
`default_nettype none

module ecg_qrs_beat_detector import eqbd_pkg::*; (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    cfg_we,
	input  wire logic [1:0]              cfg_index,
	input  wire logic [Q16_W-1:0]        cfg_data,
	input  wire logic                    in_valid,
	output logic                         in_stall,
	input  wire logic signed [X_W-1:0]   ecg_sample,
	output logic                         out_valid,
	input  wire logic                    out_stall,
	output logic                         beat_found,
	output logic [CNT_W-1:0]             sample_number,
	output logic [E_W-1:0]               energy_level
);

	// Configuration registers.
	logic [Q16_W-1:0] alpha_q, gamma_q;
	logic [LEN_W-1:0] wlen_q, hlen_q;

	// Control and running state.
	state_t            state_q;
	logic [HP_AW-1:0]  s_pos_q;
	logic [LP_AW-1:0]  h_pos_q;
	logic [SUM_W-1:0]  sum_q;
	logic [E_W-1:0]    esum_q;
	logic [E_W-1:0]    threshold_q;
	logic [WMX_W-1:0]  wmax_q;
	logic [LEN_W-1:0]  wcnt_q;
	logic              ho_act_q;
	logic [LEN_W-1:0]  ho_cnt_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [SEEN_W-1:0] seen_q;

	// Working registers of the current beat.
	logic [X_W-1:0]    x_q;
	logic [HPV_W-1:0]  hp_s1;
	logic [PROD_W-1:0] prod_q;
	logic [MA_W-1:0]   p_q;
	logic [E_W-1:0]    wm_q;
	logic [ACC_W-1:0]  acc_q;
	logic [E_W-1:0]    energy_q;
	logic              beat_q;

	// Ring memories and their registered read data.
	logic [X_W-1:0]   s_mem [HP_DEPTH];
	logic [HPV_W-1:0] h_mem [LP_DEPTH];
	logic [X_W-1:0]   s_old_q, s_ctr_q;
	logic [HPV_W-1:0] h_old_q;

	// The input is held off while reset is asserted and while a beat is in flight.
	logic accept;
	assign accept   = in_valid && !in_stall;
	assign in_stall = (state_q != ST_IDLE) || !arst_n;

	// Ring addresses: oldest entry and center tap relative to the write position.
	logic [HP_AW-1:0] s_old_addr, s_ctr_addr;
	logic [HP_AW:0]   s_ctr_sum;
	logic [LP_AW-1:0] h_old_addr;

	always_comb begin
		s_old_addr = (s_pos_q == HP_AW'(HP_DEPTH - 1)) ? '0 : s_pos_q + HP_AW'(1);
		h_old_addr = (h_pos_q == LP_AW'(LP_DEPTH - 1)) ? '0 : h_pos_q + LP_AW'(1);
		s_ctr_sum  = {1'b0, s_pos_q} + (HP_AW + 1)'(HP_CTR_OFS);
		if (s_ctr_sum >= (HP_AW + 1)'(HP_DEPTH)) begin
			s_ctr_sum = s_ctr_sum - (HP_AW + 1)'(HP_DEPTH);
		end
		s_ctr_addr = s_ctr_sum[HP_AW-1:0];
	end

	// Sample ring: written and read when a beat is accepted.
	always_ff @(posedge clk) begin
		if (accept) begin
			s_mem[s_pos_q] <= ecg_sample;
			s_old_q        <= s_mem[s_old_addr];
			s_ctr_q        <= s_mem[s_ctr_addr];
		end
	end

	// High-pass ring: read at accept, written once the new value exists.
	always_ff @(posedge clk) begin
		if (accept) begin
			h_old_q <= h_mem[h_old_addr];
		end
		if (state_q == ST_SQ) begin
			h_mem[h_pos_q] <= hp_s1;
		end
	end

	// High-pass value: moving sum update and scaled center tap.
	logic              hp_warm, lp_warm;
	logic [SUM_W-1:0]  sum_new;
	logic [HPV_W+4:0]  ctr_scaled;
	logic [HPV_W-1:0]  hp_new;

	assign hp_warm = (seen_q >= SEEN_W'(HP_LEN));
	assign lp_warm = (seen_q >= SEEN_W'(LP_LEN));

	always_comb begin
		sum_new = sum_q + {{(SUM_W-X_W){x_q[X_W-1]}}, x_q};
		if (hp_warm) begin
			sum_new = sum_new - {{(SUM_W-X_W){s_old_q[X_W-1]}}, s_old_q};
		end
		ctr_scaled = {{(HPV_W+5-X_W){s_ctr_q[X_W-1]}}, s_ctr_q} * (HPV_W + 5)'(HP_LEN);
		hp_new     = hp_warm ? (ctr_scaled[HPV_W-1:0] - HPV_W'(sum_new)) : '0;
	end

	// Shared multiplier operand selection.
	logic [MA_W-1:0]  mul_a;
	logic [MB_W-1:0]  mul_b;
	logic [HPV_W-1:0] h_old_mag, hp_mag;
	logic [Q16_W:0]   q_fac;

	assign h_old_mag = h_old_q[HPV_W-1] ? (HPV_W'(0) - h_old_q) : h_old_q;
	assign hp_mag    = hp_s1[HPV_W-1] ? (HPV_W'(0) - hp_s1) : hp_s1;
	assign q_fac     = (Q16_W + 1)'(65536) - {1'b0, alpha_q};

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			ST_HP: begin
				mul_a = MA_W'(h_old_mag);
				mul_b = MB_W'(h_old_mag);
			end
			ST_SQ: begin
				mul_a = MA_W'(hp_mag);
				mul_b = MB_W'(hp_mag);
			end
			ST_AG: begin
				mul_a = MA_W'(alpha_q);
				mul_b = MB_W'(gamma_q);
			end
			ST_QL: begin
				mul_a = MA_W'(q_fac);
				mul_b = threshold_q[23:0];
			end
			ST_QH: begin
				mul_a = MA_W'(q_fac);
				mul_b = threshold_q[47:24];
			end
			ST_WL: begin
				mul_a = p_q;
				mul_b = wm_q[23:0];
			end
			ST_WH: begin
				mul_a = p_q;
				mul_b = wm_q[47:24];
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// Detection decision for the energy of the current beat.
	logic             gt_thr, learn, ho_rel, ho_act_mid, beat_new, adapt;
	logic [LEN_W:0]   ho_inc;
	logic [LEN_W-1:0] ho_cnt_mid;
	logic [E_W-1:0]   thr_mid, esum_new;
	logic [WMX_W-1:0] wmax_new;

	always_comb begin
		esum_new   = esum_q + prod_q[E_W-1:0];
		gt_thr     = (energy_q > threshold_q);
		learn      = (seen_q < {1'b0, wlen_q}) && gt_thr;
		thr_mid    = learn ? energy_q : threshold_q;
		ho_inc     = {1'b0, ho_cnt_q} + (LEN_W + 1)'(1);
		ho_rel     = ho_act_q && (ho_inc >= {1'b0, hlen_q});
		ho_act_mid = ho_act_q && !ho_rel;
		if (ho_act_q) begin
			ho_cnt_mid = ho_rel ? '0 : ho_inc[LEN_W-1:0];
		end else begin
			ho_cnt_mid = ho_cnt_q;
		end
		beat_new = gt_thr && !learn && !ho_act_mid;
		if ($signed({1'b0, energy_q}) > $signed(wmax_q)) begin
			wmax_new = {1'b0, energy_q};
		end else begin
			wmax_new = wmax_q;
		end
		adapt = (wcnt_q >= wlen_q);
	end

	// Adapted threshold with saturation to the energy width.
	logic [E_W-1:0] thr_adapt;
	assign thr_adapt = acc_q[ACC_W-1] ? {E_W{1'b1}} : acc_q[ACC_W-2:ACC_W-1-E_W];

	logic out_load;
	assign out_load = (state_q == ST_DONE) && (!out_valid || !out_stall);

	// Datapath registers without reset.
	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		if (accept) begin
			x_q <= ecg_sample;
		end
		case (state_q)
			ST_HP: begin
				hp_s1 <= hp_new;
			end
			ST_ACC: begin
				energy_q <= lp_warm ? esum_new : '0;
			end
			ST_DEC: begin
				beat_q <= beat_new;
				wm_q   <= wmax_new[WMX_W-1] ? '0 : wmax_new[E_W-1:0];
			end
			ST_QL: begin
				p_q <= prod_q[MA_W-1:0];
			end
			ST_QH: begin
				acc_q <= {9'b0, prod_q, 16'b0};
			end
			ST_WL: begin
				acc_q <= acc_q + {prod_q[40:0], 40'b0};
			end
			ST_WH: begin
				acc_q <= acc_q + {25'b0, prod_q};
			end
			ST_WFIN: begin
				acc_q <= acc_q + {1'b0, prod_q, 24'b0};
			end
			default: begin
			end
		endcase
		if (out_load) begin
			beat_found    <= beat_q;
			sample_number <= cnt_q;
			energy_level  <= energy_q;
		end
	end

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_q <= ALPHA_RST;
			gamma_q <= GAMMA_RST;
			wlen_q  <= WLEN_RST;
			hlen_q  <= HLEN_RST;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_ALPHA: alpha_q <= cfg_data;
				REG_GAMMA: gamma_q <= cfg_data;
				REG_WLEN:  wlen_q  <= cfg_data[LEN_W-1:0];
				REG_HLEN:  hlen_q  <= cfg_data[LEN_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Sequencer and running state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			s_pos_q     <= '0;
			h_pos_q     <= '0;
			sum_q       <= '0;
			esum_q      <= '0;
			threshold_q <= '0;
			wmax_q      <= '0;
			wcnt_q      <= '0;
			ho_act_q    <= 1'b0;
			ho_cnt_q    <= '0;
			cnt_q       <= '0;
			seen_q      <= '0;
			out_valid   <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid <= 1'b1;
			end else if (!out_stall) begin
				out_valid <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						s_pos_q <= s_old_addr;
						state_q <= ST_HP;
					end
				end
				ST_HP: begin
					sum_q   <= sum_new;
					state_q <= ST_SQ;
				end
				ST_SQ: begin
					// Retire the oldest squared value first; the new one follows.
					if (lp_warm) begin
						esum_q <= esum_q - prod_q[E_W-1:0];
					end
					h_pos_q <= h_old_addr;
					state_q <= ST_ACC;
				end
				ST_ACC: begin
					esum_q  <= esum_new;
					state_q <= ST_DEC;
				end
				ST_DEC: begin
					threshold_q <= thr_mid;
					ho_act_q    <= ho_act_mid || beat_new;
					ho_cnt_q    <= ho_cnt_mid;
					if (adapt) begin
						wmax_q  <= WMAX_MIN;
						wcnt_q  <= '0;
						state_q <= ST_AG;
					end else begin
						wmax_q  <= wmax_new;
						wcnt_q  <= wcnt_q + LEN_W'(1);
						state_q <= ST_DONE;
					end
				end
				ST_AG:   state_q <= ST_QL;
				ST_QL:   state_q <= ST_QH;
				ST_QH:   state_q <= ST_WL;
				ST_WL:   state_q <= ST_WH;
				ST_WH:   state_q <= ST_WFIN;
				ST_WFIN: state_q <= ST_SAT;
				ST_SAT: begin
					threshold_q <= thr_adapt;
					state_q     <= ST_DONE;
				end
				ST_DONE: begin
					if (out_load) begin
						cnt_q <= cnt_q + CNT_W'(1);
						if (seen_q < SEEN_CAP) begin
							seen_q <= seen_q + SEEN_W'(1);
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire
